// ===== hdl/dott_pkg.sv =====
`timescale 1ns / 1ps
package dott_pkg;
  localparam int TIMER_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 48;
  localparam int NOW_W = 48;
  localparam int PER_W = 32;
  localparam int SLOT_W = 4;
  localparam int MAX_RESULTS = 16;
  localparam logic [47:0] WINDOW_RESET = 48'd3600000;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0, FN_CANCEL = 3'd1, FN_REFRESH = 3'd2, FN_RESET = 3'd3,
    FN_CHECK = 3'd4, FN_CLEAR = 3'd5, FN_QUERY = 3'd6, FN_NOP = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_INACTIVE = 2'd2, ST_SAME = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SCAN, S_EMIT, S_FIRE, S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [47:0] now_ms;
    logic [3:0]  slot;
    logic [31:0] period_ms;
    logic        loop;
    logic        restart_now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic        fired;
    logic        rearmed;
    logic [47:0] wait_ms;
    logic        last;
  } out_item_t;
endpackage

// ===== hdl/dott_if.sv =====
`timescale 1ns / 1ps
interface dott_in_if;
  import dott_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dott_out_if;
  import dott_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/deadline_ordered_timer_table_core.sv =====
`timescale 1ns / 1ps
// Timer table held in one synchronous memory (periodic flag, period, deadline per
// slot) with active bits in flip-flops. Items are handled one at a time. Add, cancel,
// clear, unused codes, a refused refresh or reset and a check on an empty table go
// from the read state straight to the result; refresh and reset first do one memory
// read, then a write unless a reset keeps the same period and does not restart. Query
// and a check with nothing due scan all slots, one slot read per cycle. A check reports
// one expiry per full scan for the earliest due deadline, as the single memory read port
// gives one slot read at a time; each expiry may also wait on the result port. The next
// item is accepted only after the last result of the current one has been taken.
module deadline_ordered_timer_table_core #(
  parameter int TIMER_SLOTS = dott_pkg::TIMER_SLOTS_DEF,
  parameter int TIME_BITS = dott_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [47:0] cfg_wdata,
  dott_in_if.sink     in_ch,
  dott_out_if.source  out_ch
);
  import dott_pkg::*;
  localparam int AW = $clog2(TIMER_SLOTS);
  localparam int MW = 1 + PER_W + TIME_BITS;
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam int RW = $clog2(MAX_RESULTS + 1);

  state_t state, state_next;
  in_item_t cur;
  logic [TIMER_SLOTS-1:0] active, due;
  logic [47:0] window, last_check;
  logic [AW:0] idx;
  logic [AW-1:0] best;
  logic best_ok;
  logic [TIME_BITS-1:0] best_dl;
  logic best_per;
  logic [PER_W-1:0] best_period;
  logic [RW-1:0] nres;
  logic roll;
  logic [TIME_BITS-1:0] now_t;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [MW-1:0] wdata, rdata;
  logic rd_per;
  logic [PER_W-1:0] rd_period;
  logic [TIME_BITS-1:0] rd_dl;
  logic [AW-1:0] rd_addr;
  logic rd_vld;

  out_item_t obuf;
  out_item_t read_res;
  logic ovalid;

  dott_mem #(.DEPTH(TIMER_SLOTS), .WIDTH(MW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  assign {rd_per, rd_period, rd_dl} = rdata;
  assign now_t = TIME_BITS'(cur.now_ms);

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
  endfunction

  logic free_found;
  logic [AW-1:0] free_slot;
  always_comb begin
    free_found = 1'b0;
    free_slot = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_slot = AW'(i);
      end
    end
  end

  logic slot_ok;
  assign slot_ok = (int'(cur.slot) < TIMER_SLOTS) && active[AW'(cur.slot)];

  logic [TIME_BITS-1:0] rd_per_t, start, wait_raw;
  assign rd_per_t = TIME_BITS'(rd_period);
  assign start = cur.restart_now ? now_t : (rd_dl >= rd_per_t ? rd_dl - rd_per_t : '0);
  assign wait_raw = best_dl - now_t;

  logic [TIMER_SLOTS-1:0] due_rest;
  logic fire_last;
  assign due_rest = due & ~(TIMER_SLOTS'(1) << best);
  assign fire_last = (due_rest == '0) || (nres == RW'(MAX_RESULTS - 1));

  assign in_ch.ready = (state == S_IDLE) && !ovalid;
  assign out_ch.valid = ovalid;
  assign out_ch.data = obuf;

  logic scan_cand;
  assign scan_cand = rd_vld &&
                     (cur.func == FN_QUERY ? active[rd_addr] :
                      (due[rd_addr] && (roll || rd_dl <= now_t))) &&
                     (!best_ok || rd_dl < best_dl);

  always_comb begin
    read_res = '{status: ST_OK, slot_out: '0, fired: 1'b0, rearmed: 1'b0,
                 wait_ms: '0, last: 1'b1};
    case (func_t'(cur.func))
      FN_ADD: begin
        if (free_found) read_res.slot_out = SLOT_W'(free_slot);
        else read_res.status = ST_FULL;
      end
      FN_CANCEL, FN_REFRESH, FN_RESET: if (!slot_ok) read_res.status = ST_INACTIVE;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_next = S_READ;
      S_READ: begin
        if (cur.func == FN_QUERY ||
            (cur.func == FN_CHECK && active != '0)) state_next = S_SCAN;
        else if ((cur.func == FN_REFRESH || cur.func == FN_RESET) && slot_ok)
          state_next = S_EMIT;
        else state_next = S_OUT;
      end
      S_SCAN: if (!rd_vld && idx == (AW+1)'(TIMER_SLOTS)) state_next = S_FIRE;
      S_EMIT: state_next = S_OUT;
      S_FIRE: if (!ovalid) begin
        if (cur.func == FN_CHECK && best_ok) state_next = fire_last ? S_IDLE : S_SCAN;
        else state_next = S_OUT;
      end
      S_OUT: if (!ovalid) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = AW'(cur.slot);
    wdata = '0;
    raddr = (state == S_SCAN) ? idx[AW-1:0] : AW'(cur.slot);
    if (state == S_READ && cur.func == FN_ADD && free_found) begin
      we = 1'b1;
      waddr = free_slot;
      wdata = {cur.loop, cur.period_ms, sat_add(now_t, TIME_BITS'(cur.period_ms))};
    end else if (state == S_EMIT && cur.func == FN_REFRESH) begin
      we = 1'b1;
      wdata = {rd_per, rd_period, sat_add(now_t, rd_per_t)};
    end else if (state == S_EMIT && cur.func == FN_RESET &&
                 !(cur.period_ms == rd_period && !cur.restart_now)) begin
      we = 1'b1;
      wdata = {rd_per, cur.period_ms, sat_add(start, TIME_BITS'(cur.period_ms))};
    end else if (state == S_FIRE && !ovalid && cur.func == FN_CHECK && best_ok &&
                 best_per) begin
      we = 1'b1;
      waddr = best;
      wdata = {best_per, best_period, sat_add(now_t, TIME_BITS'(best_period))};
    end
    if (state == S_FIRE) raddr = best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active <= '0;
      window <= WINDOW_RESET;
      last_check <= '0;
      ovalid <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) window <= cfg_wdata;
      if (ovalid && out_ch.ready) ovalid <= 1'b0;
      rd_vld <= (state == S_SCAN) && idx < (AW+1)'(TIMER_SLOTS);
      rd_addr <= raddr;
      if (state == S_SCAN && idx < (AW+1)'(TIMER_SLOTS)) idx <= idx + 1'b1;
      if (scan_cand) begin
        best_ok <= 1'b1;
        best <= rd_addr;
        best_dl <= rd_dl;
        best_per <= rd_per;
        best_period <= rd_period;
      end
      case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          cur <= in_ch.data;
          nres <= '0;
        end
        S_READ: begin
          idx <= '0;
          best_ok <= 1'b0;
          obuf <= read_res;
          case (func_t'(cur.func))
            FN_ADD: if (free_found) active[free_slot] <= 1'b1;
            FN_CANCEL: if (slot_ok) active[AW'(cur.slot)] <= 1'b0;
            FN_CHECK: if (active != '0) begin
              roll <= (last_check > 48'(now_t)) &&
                      ((last_check - 48'(now_t)) > window);
              last_check <= 48'(now_t);
              due <= active;
            end
            FN_CLEAR: active <= '0;
            default: ;
          endcase
        end
        S_SCAN: if (!rd_vld && idx == (AW+1)'(TIMER_SLOTS) && cur.func == FN_CHECK) begin
          due <= due;
        end
        S_EMIT: if (cur.func == FN_RESET && cur.period_ms == rd_period && !cur.restart_now)
          obuf.status <= ST_SAME;
        S_FIRE: if (!ovalid) begin
          idx <= '0;
          best_ok <= 1'b0;
          if (cur.func == FN_QUERY) begin
            obuf <= '{status: ST_OK, slot_out: '0, fired: 1'b0, rearmed: 1'b0,
                      wait_ms: !best_ok ? 48'hFFFF_FFFF_FFFF :
                               (now_t >= best_dl ? 48'd0 :
                               ((64'(wait_raw) > 64'h0000_FFFF_FFFF_FFFE) ?
                                48'hFFFF_FFFF_FFFE : 48'(wait_raw))),
                      last: 1'b1};
          end else if (best_ok) begin
            due[best] <= 1'b0;
            if (!best_per) active[best] <= 1'b0;
            nres <= nres + 1'b1;
            obuf <= '{status: ST_OK, slot_out: SLOT_W'(best), fired: 1'b1,
                      rearmed: best_per, wait_ms: '0, last: fire_last};
            ovalid <= 1'b1;
          end
        end
        S_OUT: if (!ovalid) ovalid <= 1'b1;
        default: ;
      endcase
      if (state == S_SCAN && rd_vld && cur.func == FN_CHECK && due[rd_addr] &&
          !roll && rd_dl > now_t)
        due[rd_addr] <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) ovalid && !out_ch.ready |=> ovalid);
  assert property (@(posedge clk) disable iff (rst) in_ch.ready |-> state == S_IDLE);
  assert property (@(posedge clk) disable iff (rst)
                   state == S_FIRE && !ovalid && cur.func == FN_CHECK && best_ok
                   |=> !due[$past(best)])
    else $error("fired slot still due");
endmodule

// ===== hdl/dott_mem.sv =====
`timescale 1ns / 1ps
module dott_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 81
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sim/deadline_ordered_timer_table_core_test.sv =====
`timescale 1ns / 1ps
module deadline_ordered_timer_table_core_test;
  import dott_pkg::*;

  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [47:0] cfg_wdata = '0;

  dott_in_if in_ch ();
  dott_out_if out_ch ();

  deadline_ordered_timer_table_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  // timer table shadow
  logic        tm_active [16];
  logic        tm_periodic [16];
  logic [31:0] tm_period [16];
  logic [47:0] tm_deadline [16];
  logic [47:0] last_check;
  logic [47:0] window;

  out_item_t timer_results [$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  logic [47:0] clock_ms = 48'd1000;

  function automatic logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? TMAX : s[47:0];
  endfunction

  function automatic out_item_t mk(logic [1:0] st, logic [3:0] sl, logic fi, logic re,
                                   logic [47:0] w, logic la);
    out_item_t r;
    r.status = st; r.slot_out = sl; r.fired = fi; r.rearmed = re;
    r.wait_ms = w; r.last = la;
    return r;
  endfunction

  task automatic queue_result(out_item_t r);
    timer_results = {timer_results, r};
  endtask

  task automatic predict_timer_op(in_item_t it);
    logic ok;
    logic due [16];
    logic any;
    logic roll;
    logic [47:0] start;
    logic [47:0] w;
    int n;
    int best;
    int slot_free;
    ok = tm_active[it.slot];
    case (func_t'(it.func))
      FN_ADD: begin
        slot_free = -1;
        for (int i = 15; i >= 0; i--) if (!tm_active[i]) slot_free = i;
        if (slot_free < 0) begin
          queue_result(mk(ST_FULL, 0, 0, 0, 0, 1));
        end else begin
          tm_active[slot_free] = 1'b1;
          tm_periodic[slot_free] = it.loop;
          tm_period[slot_free] = it.period_ms;
          tm_deadline[slot_free] = sat_sum(it.now_ms, {16'd0, it.period_ms});
          queue_result(mk(ST_OK, slot_free[3:0], 0, 0, 0, 1));
        end
      end
      FN_CANCEL: begin
        if (ok) tm_active[it.slot] = 1'b0;
        queue_result(mk(ok ? ST_OK : ST_INACTIVE, 0, 0, 0, 0, 1));
      end
      FN_REFRESH: begin
        if (ok) tm_deadline[it.slot] = sat_sum(it.now_ms, {16'd0, tm_period[it.slot]});
        queue_result(mk(ok ? ST_OK : ST_INACTIVE, 0, 0, 0, 0, 1));
      end
      FN_RESET: begin
        if (!ok) begin
          queue_result(mk(ST_INACTIVE, 0, 0, 0, 0, 1));
        end else if (it.period_ms == tm_period[it.slot] && !it.restart_now) begin
          queue_result(mk(ST_SAME, 0, 0, 0, 0, 1));
        end else begin
          if (it.restart_now) start = it.now_ms;
          else if (tm_deadline[it.slot] >= {16'd0, tm_period[it.slot]})
            start = tm_deadline[it.slot] - {16'd0, tm_period[it.slot]};
          else start = '0;
          tm_period[it.slot] = it.period_ms;
          tm_deadline[it.slot] = sat_sum(start, {16'd0, it.period_ms});
          queue_result(mk(ST_OK, 0, 0, 0, 0, 1));
        end
      end
      FN_CHECK: begin
        any = 1'b0;
        for (int i = 0; i < 16; i++) any |= tm_active[i];
        n = 0;
        if (any) begin
          roll = it.now_ms < last_check && (last_check - it.now_ms) > window;
          last_check = it.now_ms;
          for (int i = 0; i < 16; i++)
            due[i] = tm_active[i] && (roll || tm_deadline[i] <= it.now_ms);
          while (n < MAX_RESULTS) begin
            best = -1;
            for (int i = 0; i < 16; i++)
              if (due[i] && (best < 0 || tm_deadline[i] < tm_deadline[best])) best = i;
            if (best < 0) break;
            due[best] = 1'b0;
            if (tm_periodic[best])
              tm_deadline[best] = sat_sum(it.now_ms, {16'd0, tm_period[best]});
            else tm_active[best] = 1'b0;
            queue_result(mk(ST_OK, best[3:0], 1, tm_periodic[best], 0, 0));
            n++;
          end
        end
        if (n == 0) queue_result(mk(ST_OK, 0, 0, 0, 0, 1));
        else timer_results[$].last = 1'b1;
      end
      FN_CLEAR: begin
        for (int i = 0; i < 16; i++) tm_active[i] = 1'b0;
        queue_result(mk(ST_OK, 0, 0, 0, 0, 1));
      end
      FN_QUERY: begin
        best = -1;
        for (int i = 0; i < 16; i++)
          if (tm_active[i] && (best < 0 || tm_deadline[i] < tm_deadline[best])) best = i;
        if (best < 0) w = TMAX;
        else if (it.now_ms >= tm_deadline[best]) w = '0;
        else begin
          w = tm_deadline[best] - it.now_ms;
          if (w > TMAX - 1) w = TMAX - 1;
        end
        queue_result(mk(ST_OK, 0, 0, 0, w, 1));
      end
      default: queue_result(mk(ST_OK, 0, 0, 0, 0, 1));
    endcase
  endtask

  task automatic send_op(func_t f, logic [47:0] now, logic [3:0] sl,
                         logic [31:0] per, logic lp, logic fn);
    in_item_t it;
    it.func = f; it.now_ms = now; it.slot = sl; it.period_ms = per;
    it.loop = lp; it.restart_now = fn;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_timer_op(it);
  endtask

  always @(posedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (timer_results.size() == 0) begin
        $error("unexpected result %p", out_ch.data);
        errors++;
      end else begin
        e = timer_results.pop_front();
        if (out_ch.data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_ch.data.status); errors++;
        end
        if (out_ch.data.slot_out !== e.slot_out) begin
          $error("slot_out exp %0d got %0d", e.slot_out, out_ch.data.slot_out); errors++;
        end
        if (out_ch.data.fired !== e.fired) begin
          $error("fired exp %0d got %0d", e.fired, out_ch.data.fired); errors++;
        end
        if (out_ch.data.rearmed !== e.rearmed) begin
          $error("rearmed exp %0d got %0d", e.rearmed, out_ch.data.rearmed); errors++;
        end
        if (out_ch.data.wait_ms !== e.wait_ms) begin
          $error("wait_ms exp %0h got %0h", e.wait_ms, out_ch.data.wait_ms); errors++;
        end
        if (out_ch.data.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_ch.data.last); errors++;
        end
      end
    end
  end

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (timer_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_window(logic [47:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    window = v;
  endtask

  function automatic logic [31:0] rand_period();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(200);
    endcase
  endfunction

  task automatic test_directed;
    send_op(FN_QUERY, 48'd0, 0, 0, 0, 0);
    send_op(FN_CHECK, 48'd500, 0, 0, 0, 0);
    send_op(FN_CANCEL, 48'd0, 4'd15, 0, 0, 0);
    send_op(FN_REFRESH, 48'd0, 4'd3, 0, 0, 0);
    send_op(FN_RESET, 48'd0, 4'd3, 0, 0, 1);
    send_op(FN_NOP, TMAX, 4'hF, 32'hFFFF_FFFF, 1, 1);
    for (int i = 0; i < 16; i++)
      send_op(FN_ADD, 48'd100, 4'd0, (i == 15) ? 32'hFFFF_FFFF : 32'd10 + i[31:0], i[0], 0);
    send_op(FN_ADD, 48'd100, 0, 5, 0, 0);
    send_op(FN_RESET, 48'd100, 4'd2, 32'd12, 0, 0);
    send_op(FN_RESET, 48'd100, 4'd2, 32'd20, 0, 0);
    send_op(FN_REFRESH, TMAX, 4'd1, 0, 0, 0);
    send_op(FN_QUERY, 48'd50, 0, 0, 0, 0);
    send_op(FN_CHECK, 48'd10000, 0, 0, 0, 0);
    send_op(FN_CHECK, 48'd1, 0, 0, 0, 0);
    send_op(FN_QUERY, TMAX, 0, 0, 0, 0);
    send_op(FN_CLEAR, 48'd0, 0, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    int r;
    logic [3:0] sl;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if ($urandom_range(19) == 0) clock_ms = 48'({$urandom, $urandom});
      else if ($urandom_range(9) == 0) clock_ms = clock_ms - 48'($urandom_range(5000000));
      else clock_ms = clock_ms + 48'($urandom_range(60));
      sl = 4'($urandom_range(15));
      if (r < 30) send_op(FN_ADD, clock_ms, sl, rand_period(), 1'($urandom), 1'($urandom));
      else if (r < 37)
        send_op(FN_CANCEL, clock_ms, sl, $urandom, 1'($urandom), 1'($urandom));
      else if (r < 45)
        send_op(FN_REFRESH, clock_ms, sl, $urandom, 1'($urandom), 1'($urandom));
      else if (r < 57) send_op(FN_RESET, clock_ms, sl,
                               ($urandom_range(2) == 0) ? 32'd0 : rand_period(),
                               1'($urandom), 1'($urandom));
      else if (r < 82)
        send_op(FN_CHECK, clock_ms, sl, $urandom, 1'($urandom), 1'($urandom));
      else if (r < 85)
        send_op(FN_CLEAR, clock_ms, sl, $urandom, 1'($urandom), 1'($urandom));
      else if (r < 97)
        send_op(FN_QUERY, clock_ms, sl, $urandom, 1'($urandom), 1'($urandom));
      else send_op(FN_NOP, clock_ms, sl, $urandom, 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    for (int i = 0; i < 16; i++) tm_active[i] = 1'b0;
    last_check = '0;
    window = WINDOW_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_window(48'd0);
    test_random(110);
    send_idle = 52;
    write_window(TMAX);
    test_random(110);
    drain();
    send_idle = 0; recv_stall = 52;
    write_window(48'd1000);
    test_random(110);
    send_idle = 16; recv_stall = 16;
    write_window(WINDOW_RESET);
    test_random(110);
    drain();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/dott_pkg.sv
hdl/dott_if.sv
hdl/dott_mem.sv
hdl/deadline_ordered_timer_table_core.sv
sim/deadline_ordered_timer_table_core_test.sv
